FILE: sv/nsfr_pkg.sv
// Shared types, character codes and helper functions for the NMEA sentence filter.
package nsfr_pkg;

    // Input request: one frame payload byte with its framing marks
    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_first;
        logic       frame_last;
    } nsfr_in_t;

    // Closing status of a sentence attempt
    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_TYPE   = 3'd1,
        STAT_CRLF   = 3'd2,
        STAT_DIGITS = 3'd3,
        STAT_MISMATCH = 3'd4
    } nsfr_status_t;

    // Result request
    typedef struct packed {
        logic [7:0]   out_byte;
        logic         byte_valid;
        logic         sentence_end;
        nsfr_status_t status;
        logic         item_last;
    } nsfr_out_t;

    // Results of one parser step, handed to the output queue
    typedef struct packed {
        logic [1:0] cnt;
        nsfr_out_t  r0;
        nsfr_out_t  r1;
    } nsfr_push_t;

    // Parser phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_BODY   = 3'd2,
        PH_DIG1   = 3'd3,
        PH_DIG2   = 3'd4,
        PH_TAIL   = 3'd5,
        PH_LF     = 3'd6
    } nsfr_phase_t;

    localparam logic [7:0]  CH_DOLLAR = 8'h24;
    localparam logic [7:0]  CH_STAR   = 8'h2A;
    localparam logic [7:0]  CH_COMMA  = 8'h2C;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [23:0] TYPE_RESET = 24'h5A4441;   // "ZDA"

    // Output queue depth and index widths
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Hex digit decode, either case: {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

    // Nibble to uppercase hex character
    function automatic logic [7:0] hex_upper(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
            r = 8'h30 + {4'd0, v};
        else
            r = 8'h37 + {4'd0, v};
        return r;
    endfunction

endpackage

FILE: sv/nmea_sentence_filter_rewrite.sv
// Top level of the NMEA sentence filter and checksum rewriter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------
//  in      | in        | in_valid / in_stall  | in_data   (nsfr_in_t)
//  out     | out       | out_valid / out_stall| out_data  (nsfr_out_t)
//  cfg     | in        | cfg_valid / cfg_ready| cfg_data  (sentence type)
//
// One byte per cycle while in_stall is low: a request is held in the input register,
// is parsed in a single pass and lands in a four-entry result queue. Results average
// at most one per byte, so the input stalls only behind out_stall: in_stall rises
// when the input register holds a byte and the queue has fewer than two free entries.
// Asynchronous reset clears parser state and queue pointers; out_stall just holds the
// queue head.
module nmea_sentence_filter_rewrite (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  nsfr_pkg::nsfr_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output nsfr_pkg::nsfr_out_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [23:0]          cfg_data
);

    logic                        in_valid_reg;
    nsfr_pkg::nsfr_in_t          in_item_reg;
    logic [23:0]                 type_reg;
    logic                        room;
    logic                        step;
    logic [nsfr_pkg::QCNT_W-1:0] q_count;
    nsfr_pkg::nsfr_push_t        push;

    assign cfg_ready = 1'b1;
    assign step      = in_valid_reg && room;
    assign in_stall  = in_valid_reg && !room;

    // Sentence type register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            type_reg <= nsfr_pkg::TYPE_RESET;
        else if (cfg_valid && cfg_ready)
            type_reg <= cfg_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_data;
    end

    nsfr_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (in_item_reg),
        .sentence_type (type_reg),
        .push          (push)
    );

    nsfr_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (step),
        .push      (push),
        .room      (room),
        .count     (q_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Queue never fills past its depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= nsfr_pkg::QCNT_W'(nsfr_pkg::QDEPTH))
        else $error("result queue overflow");

    // A two-result step marks only its second result as last
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && push.cnt == 2'd2) |-> (!push.r0.item_last && push.r1.item_last))
        else $error("item_last misplaced on paired results");

    // A closing result is always the last one of its byte
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.sentence_end) |-> out_data.item_last)
        else $error("sentence_end without item_last");

endmodule

FILE: sv/nsfr_parser.sv
// Sentence parser: state registers and the per-byte step logic.
module nsfr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  nsfr_pkg::nsfr_in_t item,
    input  logic [23:0]       sentence_type,
    output nsfr_pkg::nsfr_push_t push
);

    nsfr_pkg::nsfr_phase_t phase_reg, phase_next, ph;
    logic [2:0] pos_reg, pos_next, pos;
    logic [7:0] xs_reg, xs_next, xs;
    logic       ch_reg, ch_next, ch;
    logic       cd_reg, cd_next, cd;
    logic [3:0] hn_reg, hn_next, hn;
    logic       dm_reg, dm_next, dm;

    logic [7:0] b;
    logic [7:0] b0, b1;
    logic [1:0] nb;
    logic [1:0] n;
    logic       end_f;
    nsfr_pkg::nsfr_status_t st;
    logic [4:0] hv;
    logic [7:0] want;
    logic [7:0] fixed_sum;

    assign b         = item.in_byte;
    assign hv        = nsfr_pkg::hex_value(b);
    assign fixed_sum = xs ^ nsfr_pkg::CH_COMMA;

    // Type character expected at this header position
    always_comb
    begin
        unique case (pos)
            3'd3:    want = sentence_type[23:16];
            3'd4:    want = sentence_type[15:8];
            default: want = sentence_type[7:0];
        endcase
    end

    // Effective state: a frame start restarts the parser
    always_comb
    begin
        if (item.frame_first)
        begin
            ph  = nsfr_pkg::PH_HEADER;
            pos = 3'd0;
            xs  = 8'd0;
            ch  = 1'b0;
            cd  = 1'b0;
            hn  = 4'd0;
            dm  = 1'b0;
        end
        else
        begin
            ph  = phase_reg;
            pos = pos_reg;
            xs  = xs_reg;
            ch  = ch_reg;
            cd  = cd_reg;
            hn  = hn_reg;
            dm  = dm_reg;
        end
    end

    // Step logic
    always_comb
    begin
        phase_next = ph;
        pos_next   = pos;
        xs_next    = xs;
        ch_next    = ch;
        cd_next    = cd;
        hn_next    = hn;
        dm_next    = dm;
        b0         = 8'd0;
        b1         = 8'd0;
        nb         = 2'd0;
        end_f      = 1'b0;
        st         = nsfr_pkg::STAT_OK;

        unique case (ph)
            nsfr_pkg::PH_IDLE:
            begin
            end
            nsfr_pkg::PH_HEADER:
            begin
                priority if (pos == 3'd0)
                begin
                    if (b != nsfr_pkg::CH_DOLLAR)
                    begin
                        end_f = 1'b1;
                        st    = nsfr_pkg::STAT_TYPE;
                    end
                    else
                    begin
                        b0 = b;
                        nb = 2'd1;
                    end
                end
                else if (b == nsfr_pkg::CH_CR)
                begin
                    end_f = 1'b1;
                    st    = nsfr_pkg::STAT_CRLF;
                end
                else if (pos <= 3'd2)
                begin
                    if (b == nsfr_pkg::CH_STAR)
                    begin
                        end_f = 1'b1;
                        st    = nsfr_pkg::STAT_TYPE;
                    end
                    else
                    begin
                        xs_next = xs ^ b;
                        b0      = b;
                        nb      = 2'd1;
                    end
                end
                else if (pos <= 3'd5)
                begin
                    if (b != want)
                    begin
                        end_f = 1'b1;
                        st    = nsfr_pkg::STAT_TYPE;
                    end
                    else
                    begin
                        xs_next = xs ^ b;
                        b0      = b;
                        nb      = 2'd1;
                    end
                end
                else
                begin
                    if (b != nsfr_pkg::CH_COMMA)
                    begin
                        end_f = 1'b1;
                        st    = nsfr_pkg::STAT_TYPE;
                    end
                    else
                    begin
                        xs_next    = xs ^ b;
                        ch_next    = 1'b1;
                        phase_next = nsfr_pkg::PH_BODY;
                    end
                end
                if (!end_f)
                    pos_next = pos + 3'd1;
            end
            nsfr_pkg::PH_BODY:
            begin
                priority if (b == nsfr_pkg::CH_CR)
                begin
                    end_f = 1'b1;
                    st    = nsfr_pkg::STAT_CRLF;
                end
                else if (b == nsfr_pkg::CH_STAR)
                begin
                    // comma right before '*' is dropped
                    if (ch)
                    begin
                        cd_next = 1'b1;
                        ch_next = 1'b0;
                    end
                    b0         = b;
                    nb         = 2'd1;
                    phase_next = nsfr_pkg::PH_DIG1;
                end
                else if (b == nsfr_pkg::CH_COMMA)
                begin
                    if (ch)
                    begin
                        b0 = nsfr_pkg::CH_COMMA;
                        nb = 2'd1;
                    end
                    ch_next = 1'b1;
                    xs_next = xs ^ b;
                end
                else
                begin
                    if (ch)
                    begin
                        b0 = nsfr_pkg::CH_COMMA;
                        b1 = b;
                        nb = 2'd2;
                    end
                    else
                    begin
                        b0 = b;
                        nb = 2'd1;
                    end
                    ch_next = 1'b0;
                    xs_next = xs ^ b;
                end
            end
            nsfr_pkg::PH_DIG1:
            begin
                if (!hv[4])
                begin
                    end_f = 1'b1;
                    st    = nsfr_pkg::STAT_DIGITS;
                end
                else
                begin
                    hn_next    = hv[3:0];
                    b0         = cd ? nsfr_pkg::hex_upper(fixed_sum[7:4]) : b;
                    nb         = 2'd1;
                    phase_next = nsfr_pkg::PH_DIG2;
                end
            end
            nsfr_pkg::PH_DIG2:
            begin
                if (!hv[4])
                begin
                    end_f = 1'b1;
                    st    = nsfr_pkg::STAT_DIGITS;
                end
                else
                begin
                    dm_next    = ({hn, hv[3:0]} == xs);
                    b0         = cd ? nsfr_pkg::hex_upper(fixed_sum[3:0]) : b;
                    nb         = 2'd1;
                    phase_next = nsfr_pkg::PH_TAIL;
                end
            end
            nsfr_pkg::PH_TAIL:
            begin
                b0 = b;
                nb = 2'd1;
                if (b == nsfr_pkg::CH_CR)
                    phase_next = nsfr_pkg::PH_LF;
            end
            nsfr_pkg::PH_LF:
            begin
                end_f = 1'b1;
                if (b != nsfr_pkg::CH_LF)
                    st = nsfr_pkg::STAT_CRLF;
                else
                begin
                    b0 = b;
                    nb = 2'd1;
                    st = dm ? nsfr_pkg::STAT_OK : nsfr_pkg::STAT_MISMATCH;
                end
            end
            default:
            begin
                phase_next = nsfr_pkg::PH_IDLE;
            end
        endcase

        // frame ends with the attempt still open
        if (ph != nsfr_pkg::PH_IDLE && phase_next != nsfr_pkg::PH_IDLE
            && !end_f && item.frame_last)
        begin
            end_f = 1'b1;
            priority if (phase_next == nsfr_pkg::PH_HEADER)
                st = nsfr_pkg::STAT_TYPE;
            else if (phase_next == nsfr_pkg::PH_DIG1 || phase_next == nsfr_pkg::PH_DIG2)
                st = nsfr_pkg::STAT_DIGITS;
            else
                st = nsfr_pkg::STAT_CRLF;
        end
        if (end_f)
        begin
            phase_next = nsfr_pkg::PH_IDLE;
            ch_next    = 1'b0;
        end
    end

    // Result assembly: end flag rides on the last result
    always_comb
    begin
        n = (nb == 2'd0) ? {1'b0, end_f} : nb;

        push.cnt             = n;
        push.r0.out_byte     = b0;
        push.r0.byte_valid   = (nb != 2'd0);
        push.r0.item_last    = (n == 2'd1);
        push.r0.sentence_end = (n == 2'd1) && end_f;
        push.r0.status       = ((n == 2'd1) && end_f) ? st : nsfr_pkg::STAT_OK;
        push.r1.out_byte     = b1;
        push.r1.byte_valid   = (nb == 2'd2);
        push.r1.item_last    = 1'b1;
        push.r1.sentence_end = end_f;
        push.r1.status       = end_f ? st : nsfr_pkg::STAT_OK;
    end

    // State registers, updated on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nsfr_pkg::PH_IDLE;
            pos_reg   <= 3'd0;
            xs_reg    <= 8'd0;
            ch_reg    <= 1'b0;
            cd_reg    <= 1'b0;
            hn_reg    <= 4'd0;
            dm_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            xs_reg    <= xs_next;
            ch_reg    <= ch_next;
            cd_reg    <= cd_next;
            hn_reg    <= hn_next;
            dm_reg    <= dm_next;
        end
    end

endmodule

FILE: sv/nsfr_out_queue.sv
// Result queue: takes up to two results per cycle, gives one per cycle while out_stall is low.
module nsfr_out_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push_en,
    input  nsfr_pkg::nsfr_push_t          push,
    output logic                          room,
    output logic [nsfr_pkg::QCNT_W-1:0]   count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output nsfr_pkg::nsfr_out_t           out_data
);

    nsfr_pkg::nsfr_out_t mem_reg [nsfr_pkg::QDEPTH];
    logic [nsfr_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [nsfr_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [nsfr_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic [nsfr_pkg::QCNT_W-1:0] n_in;
    logic                        pop;
    logic [nsfr_pkg::QPTR_W-1:0] wr_plus1;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign pop       = out_valid && !out_stall;
    // room for a full two-result step
    assign room      = (cnt_reg <= nsfr_pkg::QCNT_W'(nsfr_pkg::QDEPTH - 2));
    assign count     = cnt_reg;
    assign n_in      = push_en ? nsfr_pkg::QCNT_W'(push.cnt) : '0;
    assign wr_plus1  = wr_reg + 1'b1;

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_next  = wr_reg + nsfr_pkg::QPTR_W'(n_in);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + n_in - nsfr_pkg::QCNT_W'(pop);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_en && push.cnt != 2'd0)
            mem_reg[wr_reg] <= push.r0;
        if (push_en && push.cnt == 2'd2)
            mem_reg[wr_plus1] <= push.r1;
    end

endmodule

FILE: bench/tb.sv
// Testbench for the NMEA sentence filter: directed table, then random sentences.
module tb;

    localparam int TARGET_REQS    = 1350;
    localparam int N_SETTINGS     = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 400;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    nsfr_pkg::nsfr_in_t  in_data;
    logic                out_valid;
    logic                out_stall;
    nsfr_pkg::nsfr_out_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [23:0]         cfg_data;

    nmea_sentence_filter_rewrite DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sentence tracker state, mirrors the parser
    logic [23:0]           type_reg    = nsfr_pkg::TYPE_RESET;
    nsfr_pkg::nsfr_phase_t sn_phase    = nsfr_pkg::PH_IDLE;
    logic [2:0]            sn_pos      = 3'd0;
    logic [7:0]            sn_sum      = 8'h00;
    logic                  sn_comma    = 1'b0;
    logic                  sn_dropped  = 1'b0;
    logic [3:0]            sn_high     = 4'h0;
    logic                  sn_match    = 1'b0;

    nsfr_pkg::nsfr_out_t pending_out[$];     // results still owed by the block
    logic [7:0]          line_q[$];          // sentence being built
    int                  star_at;
    logic [23:0]         type_plan[N_SETTINGS];

    typedef struct {
        nsfr_pkg::nsfr_in_t  req;
        bit                  typed;
        nsfr_pkg::nsfr_out_t want;
    } plan_row_t;
    plan_row_t   plan[$];

    bit                  quiet     = 1'b0;
    int                  gap_pct   = 20;
    int                  stall_pct = 20;
    int                  errors    = 0;
    int                  reqs_sent = 0;
    int                  stim_reqs = 0;
    int                  results_seen = 0;
    int                  end_tally[8];
    int                  idle_cycles = 0;
    nsfr_pkg::nsfr_out_t head;

    // Hex digit value, either case; -1 when not a hex digit
    function automatic int nib_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 8'h30;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 8'h37;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 8'h57;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10)
            return 8'h30 + {4'd0, v};
        return (lower ? 8'h57 : 8'h37) + {4'd0, v};
    endfunction

    // One parser step: updates the tracker and returns the results this byte causes
    function automatic int parse_byte(input nsfr_pkg::nsfr_in_t req,
                                      output nsfr_pkg::nsfr_out_t r0,
                                      output nsfr_pkg::nsfr_out_t r1);
        logic [7:0]             b;
        logic [7:0]             fwd[$];
        logic [7:0]             want;
        logic [7:0]             fixed;
        logic [2:0]             pos;
        bit                     done;
        bit                     tip;
        int                     v;
        int                     n;
        nsfr_pkg::nsfr_status_t st;
        nsfr_pkg::nsfr_out_t    r;
        b    = req.in_byte;
        done = 1'b0;
        st   = nsfr_pkg::STAT_OK;
        r0   = '0;
        r1   = '0;
        if (req.frame_first)
        begin
            sn_phase   = nsfr_pkg::PH_HEADER;
            sn_pos     = 3'd0;
            sn_sum     = 8'h00;
            sn_comma   = 1'b0;
            sn_dropped = 1'b0;
            sn_high    = 4'h0;
            sn_match   = 1'b0;
        end
        if (sn_phase == nsfr_pkg::PH_IDLE)
            return 0;
        fixed = sn_sum ^ nsfr_pkg::CH_COMMA;
        case (sn_phase)
            nsfr_pkg::PH_HEADER:
            begin
                pos = sn_pos;
                if (pos == 3'd0)
                begin
                    if (b != nsfr_pkg::CH_DOLLAR)
                    begin
                        done = 1'b1;
                        st   = nsfr_pkg::STAT_TYPE;
                    end
                    else
                        fwd.push_back(b);
                end
                else if (b == nsfr_pkg::CH_CR)
                begin
                    done = 1'b1;
                    st   = nsfr_pkg::STAT_CRLF;
                end
                else if (pos <= 3'd2)
                begin
                    // talker characters: anything but '*' or CR
                    if (b == nsfr_pkg::CH_STAR)
                    begin
                        done = 1'b1;
                        st   = nsfr_pkg::STAT_TYPE;
                    end
                    else
                    begin
                        sn_sum ^= b;
                        fwd.push_back(b);
                    end
                end
                else if (pos <= 3'd5)
                begin
                    want = 8'(type_reg >> (8 * (5 - int'(pos))));
                    if (b != want)
                    begin
                        done = 1'b1;
                        st   = nsfr_pkg::STAT_TYPE;
                    end
                    else
                    begin
                        sn_sum ^= b;
                        fwd.push_back(b);
                    end
                end
                else
                begin
                    // comma after the type is held back
                    if (b != nsfr_pkg::CH_COMMA)
                    begin
                        done = 1'b1;
                        st   = nsfr_pkg::STAT_TYPE;
                    end
                    else
                    begin
                        sn_sum  ^= b;
                        sn_comma = 1'b1;
                        sn_phase = nsfr_pkg::PH_BODY;
                    end
                end
                if (!done)
                    sn_pos = pos + 3'd1;
            end
            nsfr_pkg::PH_BODY:
            begin
                if (b == nsfr_pkg::CH_CR)
                begin
                    done = 1'b1;
                    st   = nsfr_pkg::STAT_CRLF;
                end
                else if (b == nsfr_pkg::CH_STAR)
                begin
                    // a held comma right before '*' is dropped
                    if (sn_comma)
                    begin
                        sn_dropped = 1'b1;
                        sn_comma   = 1'b0;
                    end
                    fwd.push_back(b);
                    sn_phase = nsfr_pkg::PH_DIG1;
                end
                else if (b == nsfr_pkg::CH_COMMA)
                begin
                    if (sn_comma)
                        fwd.push_back(nsfr_pkg::CH_COMMA);
                    sn_comma = 1'b1;
                    sn_sum  ^= b;
                end
                else
                begin
                    if (sn_comma)
                    begin
                        fwd.push_back(nsfr_pkg::CH_COMMA);
                        sn_comma = 1'b0;
                    end
                    fwd.push_back(b);
                    sn_sum ^= b;
                end
            end
            nsfr_pkg::PH_DIG1:
            begin
                v = nib_of(b);
                if (v < 0)
                begin
                    done = 1'b1;
                    st   = nsfr_pkg::STAT_DIGITS;
                end
                else
                begin
                    sn_high = 4'(v);
                    fwd.push_back(sn_dropped ? hex_char(fixed[7:4], 1'b0) : b);
                    sn_phase = nsfr_pkg::PH_DIG2;
                end
            end
            nsfr_pkg::PH_DIG2:
            begin
                v = nib_of(b);
                if (v < 0)
                begin
                    done = 1'b1;
                    st   = nsfr_pkg::STAT_DIGITS;
                end
                else
                begin
                    sn_match = {sn_high, 4'(v)} == sn_sum;
                    fwd.push_back(sn_dropped ? hex_char(fixed[3:0], 1'b0) : b);
                    sn_phase = nsfr_pkg::PH_TAIL;
                end
            end
            nsfr_pkg::PH_TAIL:
            begin
                fwd.push_back(b);
                if (b == nsfr_pkg::CH_CR)
                    sn_phase = nsfr_pkg::PH_LF;
            end
            nsfr_pkg::PH_LF:
            begin
                done = 1'b1;
                if (b != nsfr_pkg::CH_LF)
                    st = nsfr_pkg::STAT_CRLF;
                else
                begin
                    fwd.push_back(b);
                    st = sn_match ? nsfr_pkg::STAT_OK : nsfr_pkg::STAT_MISMATCH;
                end
            end
            default:
            begin
                sn_phase = nsfr_pkg::PH_IDLE;
                return 0;
            end
        endcase

        // frame closed before the sentence finished
        if (!done && req.frame_last)
        begin
            done = 1'b1;
            if (sn_phase == nsfr_pkg::PH_HEADER)
                st = nsfr_pkg::STAT_TYPE;
            else if (sn_phase == nsfr_pkg::PH_DIG1 || sn_phase == nsfr_pkg::PH_DIG2)
                st = nsfr_pkg::STAT_DIGITS;
            else
                st = nsfr_pkg::STAT_CRLF;
        end
        if (done)
        begin
            sn_phase = nsfr_pkg::PH_IDLE;
            sn_comma = 1'b0;
        end

        n = fwd.size();
        if (n == 0)
        begin
            if (!done)
                return 0;
            n = 1;
        end
        for (int k = 0; k < n; k++)
        begin
            tip            = (k == n - 1);
            r.out_byte     = (k < fwd.size()) ? fwd[k] : 8'h00;
            r.byte_valid   = k < fwd.size();
            r.sentence_end = done && tip;
            r.status       = nsfr_pkg::STAT_OK;
            if (done && tip)
                r.status = st;
            r.item_last    = tip;
            if (k == 0)
                r0 = r;
            else
                r1 = r;
        end
        return n;
    endfunction

    // Present one request, wait for it to be taken, then note its results
    task automatic send_req(input nsfr_pkg::nsfr_in_t req, input bit typed = 1'b0,
                            input nsfr_pkg::nsfr_out_t want = '0);
        nsfr_pkg::nsfr_out_t r0;
        nsfr_pkg::nsfr_out_t r1;
        int                  n;
        @(negedge clk);
        if (!quiet && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = parse_byte(req, r0, r1);
        if (typed)
            pending_out.push_back(want);
        else
        begin
            if (n > 0)
                pending_out.push_back(r0);
            if (n > 1)
                pending_out.push_back(r1);
        end
        reqs_sent++;
    endtask

    task automatic plan_row(input logic [7:0] b, input bit first, input bit last,
                            input bit typed = 1'b0, input logic [7:0] ob = 8'h00,
                            input bit ov = 1'b0,
                            input nsfr_pkg::nsfr_status_t st = nsfr_pkg::STAT_OK);
        plan_row_t row;
        row.req.in_byte        = b;
        row.req.frame_first    = first;
        row.req.frame_last     = last;
        row.typed              = typed;
        row.want.out_byte      = ob;
        row.want.byte_valid    = ov;
        row.want.sentence_end  = 1'b1;
        row.want.status        = st;
        row.want.item_last     = 1'b1;
        plan.push_back(row);
    endtask

    task automatic send_line(input bit close_frame);
        nsfr_pkg::nsfr_in_t req;
        foreach (line_q[i])
        begin
            req.in_byte     = line_q[i];
            req.frame_first = (i == 0);
            req.frame_last  = close_frame && (i == line_q.size() - 1);
            send_req(req);
            stim_reqs++;
        end
    endtask

    function automatic logic [7:0] talker_char();
        logic [7:0] c;
        c = ($urandom_range(3) != 0) ? 8'h41 + 8'($urandom_range(25)) : 8'($urandom());
        while (c == nsfr_pkg::CH_STAR || c == nsfr_pkg::CH_CR)
            c = 8'($urandom());
        return c;
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        case ($urandom_range(4))
            0, 1:    c = 8'h30 + 8'($urandom_range(9));
            2:       c = nsfr_pkg::CH_COMMA;
            3:       c = ($urandom_range(1) != 0) ? 8'h2E : 8'h41 + 8'($urandom_range(25));
            default: c = 8'($urandom());
        endcase
        while (c == nsfr_pkg::CH_STAR || c == nsfr_pkg::CH_CR)
            c = 8'($urandom());
        return c;
    endfunction

    // Well-formed sentence for the current type: random fields, checksum sometimes corrupted, random digit case
    task automatic build_sentence();
        logic [7:0] sum;
        logic [7:0] c;
        line_q.delete();
        line_q.push_back(nsfr_pkg::CH_DOLLAR);
        repeat (2) line_q.push_back(talker_char());
        line_q.push_back(type_reg[23:16]);
        line_q.push_back(type_reg[15:8]);
        line_q.push_back(type_reg[7:0]);
        line_q.push_back(nsfr_pkg::CH_COMMA);
        repeat ($urandom_range(0, 10)) line_q.push_back(body_char());
        if ($urandom_range(1) != 0)
            line_q.push_back(nsfr_pkg::CH_COMMA);
        sum = 8'h00;
        for (int i = 1; i < line_q.size(); i++)
            sum ^= line_q[i];
        if ($urandom_range(3) == 0)
            sum = 8'($urandom());
        star_at = line_q.size();
        line_q.push_back(nsfr_pkg::CH_STAR);
        line_q.push_back(hex_char(sum[7:4], 1'($urandom_range(1))));
        line_q.push_back(hex_char(sum[3:0], 1'($urandom_range(1))));
        repeat ($urandom_range(0, 2))
        begin
            c = 8'($urandom());
            while (c == nsfr_pkg::CH_CR)
                c = 8'($urandom());
            line_q.push_back(c);
        end
        line_q.push_back(nsfr_pkg::CH_CR);
        line_q.push_back(nsfr_pkg::CH_LF);
    endtask

    // Broken sentence: truncated, a byte hit, bad digit or bad line end
    task automatic damage_line();
        int         cut;
        logic [7:0] c;
        case ($urandom_range(4))
            0, 2:
            begin
                cut    = $urandom_range(0, line_q.size() - 1);
                line_q = line_q[0:cut];
            end
            1:       line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom());
            3:
            begin
                c = 8'($urandom());
                while (nib_of(c) >= 0)
                    c = 8'($urandom());
                line_q[star_at + 1 + $urandom_range(1)] = c;
            end
            default:
            begin
                c = 8'($urandom());
                while (c == nsfr_pkg::CH_LF)
                    c = 8'($urandom());
                line_q[line_q.size() - 1] = c;
            end
        endcase
        send_line(1'($urandom_range(1)));
    endtask

    task automatic random_unit();
        int                 pick;
        nsfr_pkg::nsfr_in_t req;
        gap_pct   = ($urandom_range(3) == 0) ? 0 : 25;
        stall_pct = ($urandom_range(3) == 0) ? 0 : 25;
        pick      = $urandom_range(99);
        if (pick < 65)
        begin
            build_sentence();
            send_line(1'($urandom_range(1)));
        end
        else if (pick < 88)
        begin
            build_sentence();
            damage_line();
        end
        else
        begin
            // raw noise with random framing marks
            repeat ($urandom_range(1, 6))
            begin
                req.in_byte     = 8'($urandom());
                req.frame_first = ($urandom_range(3) == 0);
                req.frame_last  = ($urandom_range(3) == 0);
                send_req(req);
                stim_reqs++;
            end
        end
        // stray bytes between frames
        if ($urandom_range(4) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                req.in_byte     = 8'($urandom());
                req.frame_first = 1'b0;
                req.frame_last  = 1'($urandom_range(1));
                send_req(req);
            end
        end
    endtask

    // Type register write, only once the block has gone quiet
    task automatic write_type(input logic [23:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        type_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result stall, in bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (out_data.sentence_end)
                end_tally[out_data.status]++;
            if (pending_out.size() == 0)
            begin
                $error("unexpected result %h", out_data);
                errors++;
            end
            else
            begin
                head = pending_out.pop_front();
                if (out_data.out_byte !== head.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", head.out_byte, out_data.out_byte);
                    errors++;
                end
                if (out_data.byte_valid !== head.byte_valid)
                begin
                    $error("byte_valid: expected %b, got %b", head.byte_valid,
                           out_data.byte_valid);
                    errors++;
                end
                if (out_data.sentence_end !== head.sentence_end)
                begin
                    $error("sentence_end: expected %b, got %b", head.sentence_end,
                           out_data.sentence_end);
                    errors++;
                end
                if (out_data.status !== head.status)
                begin
                    $error("status: expected %0d, got %0d", head.status, out_data.status);
                    errors++;
                end
                if (out_data.item_last !== head.item_last)
                begin
                    $error("item_last: expected %b, got %b", head.item_last,
                           out_data.item_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no request moving anywhere
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int base;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 24'h000000;
        type_plan[0] = nsfr_pkg::TYPE_RESET;
        type_plan[1] = 24'h474741;     // "GGA"
        type_plan[2] = 24'h000000;
        type_plan[3] = 24'hFFFFFF;
        type_plan[4] = 24'($urandom());
        type_plan[5] = nsfr_pkg::TYPE_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, run with the reset sentence type
        plan_row(8'h00, 1'b0, 1'b0);                                // idle, ignored
        plan_row(8'h78, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, nsfr_pkg::STAT_TYPE);  // no '$'
        plan_row(8'hFF, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, nsfr_pkg::STAT_TYPE);
        plan_row(nsfr_pkg::CH_DOLLAR, 1'b1, 1'b1, 1'b1, nsfr_pkg::CH_DOLLAR, 1'b1,
                 nsfr_pkg::STAT_TYPE);
        plan_row(nsfr_pkg::CH_DOLLAR, 1'b1, 1'b0);
        plan_row(8'h47, 1'b0, 1'b0);
        plan_row(nsfr_pkg::CH_STAR, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0,
                 nsfr_pkg::STAT_TYPE);                              // '*' in talker
        plan_row(nsfr_pkg::CH_DOLLAR, 1'b1, 1'b0);
        plan_row(nsfr_pkg::CH_CR, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0,
                 nsfr_pkg::STAT_CRLF);                              // CR in header
        plan_row(nsfr_pkg::CH_DOLLAR, 1'b1, 1'b0);
        plan_row(8'h47, 1'b0, 1'b0);
        // restart mid-header, then a sentence whose last comma is dropped
        plan_row(nsfr_pkg::CH_DOLLAR, 1'b1, 1'b0);
        plan_row(8'h47, 1'b0, 1'b0);
        plan_row(8'h50, 1'b0, 1'b0);
        plan_row(8'h5A, 1'b0, 1'b0);
        plan_row(8'h44, 1'b0, 1'b0);
        plan_row(8'h41, 1'b0, 1'b0);
        plan_row(nsfr_pkg::CH_COMMA, 1'b0, 1'b0);
        plan_row(nsfr_pkg::CH_STAR, 1'b0, 1'b0);
        plan_row(8'h61, 1'b0, 1'b0);
        plan_row(8'h62, 1'b0, 1'b0);
        plan_row(nsfr_pkg::CH_CR, 1'b0, 1'b0);
        plan_row(nsfr_pkg::CH_LF, 1'b0, 1'b1);
        foreach (plan[i])
            send_req(plan[i].req, plan[i].typed, plan[i].want);

        // Random sentences under each type setting; the last stretch runs without idling
        for (int ph = 0; ph < N_SETTINGS; ph++)
        begin
            if (ph > 0)
                write_type(type_plan[ph]);
            quiet = (ph == N_SETTINGS - 1);
            base  = stim_reqs;
            while (stim_reqs - base < TARGET_REQS / N_SETTINGS)
                random_unit();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d requests over %0d type settings, %0d results checked",
                 reqs_sent, N_SETTINGS, results_seen);
        $display("tb: sentence ends ok %0d, header %0d, crlf %0d, digits %0d, mismatch %0d",
                 end_tally[nsfr_pkg::STAT_OK], end_tally[nsfr_pkg::STAT_TYPE],
                 end_tally[nsfr_pkg::STAT_CRLF], end_tally[nsfr_pkg::STAT_DIGITS],
                 end_tally[nsfr_pkg::STAT_MISMATCH]);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
